// ----- sv/sbe_pkg.sv -----
// Shared types and constants for the slot buffer with evict and round-robin take.
package sbe_pkg;

  localparam int SLOTS_DEF = 8;

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_EVICT = 2'd1;
  localparam logic [1:0] FUNC_TAKE  = 2'd2;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  typedef struct packed {
    logic [31:0] wait_time;
    logic [7:0]  source_id;
    logic [31:0] request_id;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_LAST = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

endpackage

// ----- sv/sbe_mem.sv -----
// Slot entry memory: one port, synchronous (registered) read.
module sbe_mem #(
  parameter int SLOTS = sbe_pkg::SLOTS_DEF,
  parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [IW-1:0]  addr_i,
  input  sbe_pkg::entry_t wdata_i,
  output sbe_pkg::entry_t rdata_o
);

  sbe_pkg::entry_t mem_q [SLOTS];
  sbe_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/sbe_ctrl.sv -----
// Operation sequencer: slot scan, selection, occupancy and take pointer.
module sbe_ctrl #(
  parameter int SLOTS = sbe_pkg::SLOTS_DEF,
  parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  logic [1:0]      func_i,
  input  sbe_pkg::entry_t req_i,
  output logic            mem_we_o,
  output logic [IW-1:0]   mem_addr_o,
  output sbe_pkg::entry_t mem_wdata_o,
  input  sbe_pkg::entry_t mem_rdata_i,
  output logic            done_o,
  output logic            status_o,
  output logic [2:0]      slot_o,
  output sbe_pkg::entry_t out_o,
  output logic            has_free_o,
  output logic            all_empty_o
);

  localparam int CNTW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] LAST_POS = IW'(SLOTS - 1);

  sbe_pkg::state_e state_q;
  logic [1:0]      func_q;
  sbe_pkg::entry_t req_q;
  sbe_pkg::entry_t best_q;
  logic [IW-1:0]   pos_q;
  logic [IW-1:0]   step_q;
  logic [IW-1:0]   cmp_pos_q;
  logic            cmp_vld_q;
  logic            found_q;
  logic [IW-1:0]   sel_q;
  logic            nxt_found_q;
  logic [IW-1:0]   nxt_q;
  logic [IW-1:0]   ptr_q;
  logic            occ_q [SLOTS];
  logic [CNTW-1:0] occ_cnt_q;
  logic [CNTW-1:0] occ_cnt_d;
  logic            done_q;
  logic            status_q;
  logic [2:0]      slot_q;
  sbe_pkg::entry_t out_q;
  logic            has_free_q;
  logic            all_empty_q;

  logic            cmp_occ;
  logic            sel_hit;
  logic            nxt_hit;
  logic [IW+2:0]   sel_ext;
  logic [IW-1:0]   pos_next;

  assign cmp_occ  = occ_q[cmp_pos_q];
  assign pos_next = (pos_q == LAST_POS) ? '0 : pos_q + IW'(1);
  assign sel_ext  = {3'b000, sel_q};

  always_comb begin
    sel_hit = 1'b0;
    nxt_hit = 1'b0;
    if (cmp_vld_q) begin
      case (func_q)
        sbe_pkg::FUNC_ADD: begin
          sel_hit = !cmp_occ && !found_q;
        end
        sbe_pkg::FUNC_EVICT: begin
          sel_hit = cmp_occ && (!found_q || (mem_rdata_i.wait_time >= best_q.wait_time));
        end
        sbe_pkg::FUNC_TAKE: begin
          sel_hit = cmp_occ && !found_q;
          nxt_hit = cmp_occ && found_q && !nxt_found_q;
        end
        default: begin
          sel_hit = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    occ_cnt_d = occ_cnt_q;
    if (found_q) begin
      if (func_q == sbe_pkg::FUNC_ADD) begin
        occ_cnt_d = occ_cnt_q + CNTW'(1);
      end else begin
        occ_cnt_d = occ_cnt_q - CNTW'(1);
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbe_pkg::ST_IDLE;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      nxt_found_q <= 1'b0;
      ptr_q       <= '0;
      occ_cnt_q   <= '0;
      done_q      <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        occ_q[i] <= 1'b0;
      end
    end else begin
      done_q <= (state_q == sbe_pkg::ST_FIN);
      if (sel_hit) begin
        found_q <= 1'b1;
      end
      if (nxt_hit) begin
        nxt_found_q <= 1'b1;
      end
      case (state_q)
        sbe_pkg::ST_IDLE: begin
          if (start_i) begin
            found_q     <= 1'b0;
            nxt_found_q <= 1'b0;
            state_q     <= sbe_pkg::ST_SCAN;
          end
        end
        sbe_pkg::ST_SCAN: begin
          cmp_vld_q <= 1'b1;
          if (step_q == LAST_POS) begin
            state_q <= sbe_pkg::ST_LAST;
          end
        end
        sbe_pkg::ST_LAST: begin
          cmp_vld_q <= 1'b0;
          state_q   <= sbe_pkg::ST_FIN;
        end
        sbe_pkg::ST_FIN: begin
          occ_cnt_q <= occ_cnt_d;
          if (found_q) begin
            occ_q[sel_q] <= (func_q == sbe_pkg::FUNC_ADD);
          end
          if (func_q == sbe_pkg::FUNC_TAKE && nxt_found_q) begin
            ptr_q <= nxt_q;
          end
          state_q <= sbe_pkg::ST_IDLE;
        end
        default: begin
          state_q <= sbe_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // payload and scan position
  always_ff @(posedge clk_i) begin
    if (sel_hit) begin
      sel_q  <= cmp_pos_q;
      best_q <= mem_rdata_i;
    end
    if (nxt_hit) begin
      nxt_q <= cmp_pos_q;
    end
    cmp_pos_q <= pos_q;
    case (state_q)
      sbe_pkg::ST_IDLE: begin
        if (start_i) begin
          func_q <= func_i;
          req_q  <= req_i;
          step_q <= '0;
          pos_q  <= (func_i == sbe_pkg::FUNC_TAKE) ? ptr_q : '0;
        end
      end
      sbe_pkg::ST_SCAN: begin
        step_q <= step_q + IW'(1);
        pos_q  <= pos_next;
      end
      sbe_pkg::ST_FIN: begin
        status_q    <= found_q ? sbe_pkg::STATUS_DONE : sbe_pkg::STATUS_REFUSED;
        slot_q      <= found_q ? sel_ext[2:0] : 3'd0;
        out_q       <= (found_q && func_q != sbe_pkg::FUNC_ADD) ? best_q : '0;
        has_free_q  <= (occ_cnt_d != CNTW'(SLOTS));
        all_empty_q <= (occ_cnt_d == '0);
      end
      default: begin
        step_q <= step_q;
      end
    endcase
  end

  assign busy_o      = (state_q != sbe_pkg::ST_IDLE);
  assign mem_we_o    = (state_q == sbe_pkg::ST_FIN) && found_q && (func_q == sbe_pkg::FUNC_ADD);
  assign mem_addr_o  = (state_q == sbe_pkg::ST_FIN) ? sel_q : pos_q;
  assign mem_wdata_o = req_q;
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;
  assign out_o       = out_q;
  assign has_free_o  = has_free_q;
  assign all_empty_o = all_empty_q;

endmodule

// ----- sv/slot_buffer_evict_round_robin.sv -----
// Top level of the request slot buffer with add, evict-largest and round-robin take.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------------------
//   request  | start_i / busy_o      | func_i, wait_time_i, source_id_i, request_id_i
//   result   | done_o (one cycle)    | status_o, slot_o, out_wait_time_o,
//            |                       | out_source_id_o, out_request_id_o,
//            |                       | has_free_o, all_empty_o
//
// Each transaction scans all slots: the sequencer reads one slot entry from the
// entry memory per cycle, then the LAST state drains the read and the FIN state
// commits; done_o strobes in the cycle after FIN. busy_o is low in the strobe
// cycle, so the next transaction is accepted at the earliest at the edge that ends
// it, and a new transaction is never taken before the last one is done. Reset
// clears occupancy, the take pointer and the sequencer; the entry memory is not
// cleared. The receiver cannot stall results.
module slot_buffer_evict_round_robin #(
  parameter int SLOTS = sbe_pkg::SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] wait_time_i,
  input  logic [7:0]  source_id_i,
  input  logic [31:0] request_id_i,
  output logic        done_o,
  output logic        status_o,
  output logic [2:0]  slot_o,
  output logic [31:0] out_wait_time_o,
  output logic [7:0]  out_source_id_o,
  output logic [31:0] out_request_id_o,
  output logic        has_free_o,
  output logic        all_empty_o
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  sbe_pkg::entry_t req;
  sbe_pkg::entry_t out_entry;
  sbe_pkg::entry_t mem_wdata;
  sbe_pkg::entry_t mem_rdata;
  logic            mem_we;
  logic [IW-1:0]   mem_addr;

  assign req.wait_time  = wait_time_i;
  assign req.source_id  = source_id_i;
  assign req.request_id = request_id_i;

  sbe_ctrl #(
    .SLOTS(SLOTS),
    .IW   (IW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .func_i     (func_i),
    .req_i      (req),
    .mem_we_o   (mem_we),
    .mem_addr_o (mem_addr),
    .mem_wdata_o(mem_wdata),
    .mem_rdata_i(mem_rdata),
    .done_o     (done_o),
    .status_o   (status_o),
    .slot_o     (slot_o),
    .out_o      (out_entry),
    .has_free_o (has_free_o),
    .all_empty_o(all_empty_o)
  );

  sbe_mem #(
    .SLOTS(SLOTS),
    .IW   (IW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  assign out_wait_time_o  = out_entry.wait_time;
  assign out_source_id_o  = out_entry.source_id;
  assign out_request_id_o = out_entry.request_id;

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the request slot buffer with evict and round-robin take.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = sbe_pkg::SLOTS_DEF;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = SLOTS + 8;

  typedef struct packed {
    logic        status;
    logic [2:0]  slot;
    logic [31:0] wait_time;
    logic [7:0]  source_id;
    logic [31:0] request_id;
    logic        has_free;
    logic        all_empty;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  func_i = sbe_pkg::FUNC_ADD;
  logic [31:0] wait_time_i = '0;
  logic [7:0]  source_id_i = '0;
  logic [31:0] request_id_i = '0;
  logic        busy_o;
  logic        done_o;
  logic        status_o;
  logic [2:0]  slot_o;
  logic [31:0] out_wait_time_o;
  logic [7:0]  out_source_id_o;
  logic [31:0] out_request_id_o;
  logic        has_free_o;
  logic        all_empty_o;

  bit              slot_held [SLOTS];
  sbe_pkg::entry_t slot_entry [SLOTS];
  int              rr_pointer;
  outcome_t        expected_q [$];
  int              mismatches;
  bit              idle_enable;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  slot_buffer_evict_round_robin #(
    .SLOTS(SLOTS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .func_i          (func_i),
    .wait_time_i     (wait_time_i),
    .source_id_i     (source_id_i),
    .request_id_i    (request_id_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .slot_o          (slot_o),
    .out_wait_time_o (out_wait_time_o),
    .out_source_id_o (out_source_id_o),
    .out_request_id_o(out_request_id_o),
    .has_free_o      (has_free_o),
    .all_empty_o     (all_empty_o)
  );

  function automatic outcome_t apply_operation(logic [1:0] op, sbe_pkg::entry_t req);
    outcome_t res;
    int       pick;
    int       cur;
    bit       found;
    bit       any_free;
    bit       any_used;
    res = '0;
    res.status = sbe_pkg::STATUS_REFUSED;
    pick = 0;
    found = 1'b0;
    case (op)
      sbe_pkg::FUNC_ADD: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && !slot_held[i]) begin
            slot_held[i] = 1'b1;
            slot_entry[i] = req;
            res.status = sbe_pkg::STATUS_DONE;
            res.slot = 3'(i);
            found = 1'b1;
          end
        end
      end
      sbe_pkg::FUNC_EVICT: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_held[i] && (!found || slot_entry[i].wait_time >= slot_entry[pick].wait_time)) begin
            pick = i;
            found = 1'b1;
          end
        end
      end
      sbe_pkg::FUNC_TAKE: begin
        cur = rr_pointer;
        for (int i = 0; i < SLOTS; i++) begin
          if (cur >= SLOTS) cur = 0;
          if (slot_held[cur]) begin
            if (!found) begin
              pick = cur;
              found = 1'b1;
              cur++;
            end
          end else begin
            cur++;
          end
        end
        if (cur >= SLOTS) cur = 0;
        rr_pointer = cur;
      end
      default: ;
    endcase
    if (found && op != sbe_pkg::FUNC_ADD) begin
      res.status = sbe_pkg::STATUS_DONE;
      res.slot = 3'(pick);
      res.wait_time = slot_entry[pick].wait_time;
      res.source_id = slot_entry[pick].source_id;
      res.request_id = slot_entry[pick].request_id;
      slot_held[pick] = 1'b0;
    end
    any_free = 1'b0;
    any_used = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_held[i]) any_used = 1'b1;
      else any_free = 1'b1;
    end
    res.has_free = any_free;
    res.all_empty = !any_used;
    return res;
  endfunction

  task automatic send_item(logic [1:0] op, logic [31:0] wt, logic [7:0] src, logic [31:0] req);
    sbe_pkg::entry_t item;
    func_i <= op;
    wait_time_i <= wt;
    source_id_i <= src;
    request_id_i <= req;
    do begin
      if (idle_enable && $urandom_range(0, 99) < 21) start_i <= 1'b0;
      else start_i <= 1'b1;
      @(posedge clk_i);
    end while (!(start_i && !busy_o));
    item.wait_time = wt;
    item.source_id = src;
    item.request_id = req;
    expected_q = {expected_q, apply_operation(op, item)};
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t ns: result with no transaction pending: expected none, actual slot %0d",
                 $time, slot_o);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        compare_field("status", want.status, status_o);
        compare_field("slot", want.slot, slot_o);
        compare_field("out_wait_time", want.wait_time, out_wait_time_o);
        compare_field("out_source_id", want.source_id, out_source_id_o);
        compare_field("out_request_id", want.request_id, out_request_id_o);
        compare_field("has_free", want.has_free, has_free_o);
        compare_field("all_empty", want.all_empty, all_empty_o);
      end
    end
  end

  function automatic logic [31:0] pick_wait_time();
    case ($urandom_range(0, 3))
      0:       return 32'($urandom_range(0, 3));
      1:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_buffer();
    send_item(sbe_pkg::FUNC_EVICT, $urandom, 8'($urandom), $urandom);
    send_item(sbe_pkg::FUNC_TAKE, $urandom, 8'($urandom), $urandom);
    send_item(FUNC_UNUSED, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_fill_to_full();
    send_item(sbe_pkg::FUNC_ADD, 32'h0, 8'h00, 32'h0);
    send_item(sbe_pkg::FUNC_ADD, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    send_item(sbe_pkg::FUNC_ADD, 32'd7, 8'h5A, 32'hA5A5_A5A5);
    send_item(sbe_pkg::FUNC_ADD, 32'd7, 8'hA5, 32'h5A5A_5A5A);
    send_item(sbe_pkg::FUNC_ADD, 32'hFFFF_FFFF, 8'h01, 32'h0000_0001);
    send_item(sbe_pkg::FUNC_ADD, 32'h8000_0000, 8'h80, 32'h8000_0000);
    send_item(sbe_pkg::FUNC_ADD, 32'h7FFF_FFFF, 8'h7F, 32'h7FFF_FFFF);
    send_item(sbe_pkg::FUNC_ADD, 32'd7, 8'h33, 32'h1234_5678);
    send_item(sbe_pkg::FUNC_ADD, 32'd9, 8'h44, 32'h8765_4321);
  endtask

  task automatic test_evict_order();
    repeat (3) send_item(sbe_pkg::FUNC_EVICT, $urandom, 8'($urandom), $urandom);
  endtask

  task automatic test_take_rotation();
    repeat (4) send_item(sbe_pkg::FUNC_TAKE, $urandom, 8'($urandom), $urandom);
    send_item(sbe_pkg::FUNC_ADD, 32'd3, 8'h10, 32'h0000_0010);
    send_item(sbe_pkg::FUNC_ADD, 32'd4, 8'h20, 32'h0000_0020);
    repeat (2) send_item(sbe_pkg::FUNC_TAKE, $urandom, 8'($urandom), $urandom);
  endtask

  task automatic test_random_traffic(int count);
    int          add_pct;
    int          roll;
    logic [1:0]  op;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       add_pct = 15;
          1:       add_pct = 50;
          default: add_pct = 85;
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) op = FUNC_UNUSED;
      else if (roll < 2 + add_pct) op = sbe_pkg::FUNC_ADD;
      else if ($urandom_range(0, 1)) op = sbe_pkg::FUNC_EVICT;
      else op = sbe_pkg::FUNC_TAKE;
      send_item(op, pick_wait_time(), 8'($urandom), $urandom);
    end
  endtask

  initial begin
    int waited;
    mismatches = 0;
    rr_pointer = 0;
    foreach (slot_held[i]) slot_held[i] = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_enable = 1'b1;
    test_empty_buffer();
    test_fill_to_full();
    test_evict_order();
    test_take_rotation();
    idle_enable = 1'b0;
    test_random_traffic(150);
    idle_enable = 1'b1;
    test_random_traffic(330);
    start_i <= 1'b0;
    waited = 0;
    while (expected_q.size() != 0 && waited < 1000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      $display("%0t ns: %0d results missing: expected %0d, actual 0", $time,
               expected_q.size(), expected_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/sbe_pkg.sv
sv/sbe_mem.sv
sv/sbe_ctrl.sv
sv/slot_buffer_evict_round_robin.sv
bench/tb_top.sv
